>>> hw/rtl/rmq_pkg.sv
// Shared types, constants and helpers for the rotation matrix to quaternion block.
`default_nettype none

package rmq_pkg;

    localparam int ELEM_WIDTH = 16;
    localparam int FRAC_BITS  = 14;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } t_branch;

    typedef struct packed {
        t_branch branch;
        logic    err;
    } t_ctl;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rmq_if.sv
// Request channel interfaces for matrix input and quaternion output.
`default_nettype none

interface rmq_in_if #(parameter int W = rmq_pkg::ELEM_WIDTH);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
    modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 output ready);
endinterface

interface rmq_out_if #(parameter int W = rmq_pkg::ELEM_WIDTH);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] qx, qy, qz, qw;
    logic [1:0]          branch;
    logic                error;

    modport source(output valid, qx, qy, qz, qw, branch, error, input ready);
    modport sink(input valid, qx, qy, qz, qw, branch, error, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rmq_front.sv
// Front stage: branch selection, radicand and off-diagonal numerators.
`default_nettype none

module rmq_front #(
    parameter int W    = rmq_pkg::ELEM_WIDTH,
    parameter int F    = rmq_pkg::FRAC_BITS,
    parameter int RW   = rmq_pkg::max_int(W, F + 1) + 3,
    parameter int NRW  = RW - 1 + F
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    rmq_in_if.sink                 i_in,
    output logic                   o_vld,
    output rmq_pkg::t_ctl          o_ctl,
    output logic [NRW-1:0]         o_rad,
    output logic [2:0]             o_neg,
    output logic [2:0][W:0]        o_mag
);

    logic signed [RW-1:0]  a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [RW-1:0]  trace, one, rad_s;
    logic signed [W+1:0]   dv [3];
    rmq_pkg::t_ctl         n_ctl;
    logic [NRW-1:0]        n_rad;
    logic [2:0]            n_neg;
    logic [2:0][W:0]       n_mag;
    logic                  r_vld;
    rmq_pkg::t_ctl         r_ctl;
    logic [NRW-1:0]        r_rad;
    logic [2:0]            r_neg;
    logic [2:0][W:0]       r_mag;

    assign i_in.ready = i_en;

    assign a00 = RW'(i_in.m00);
    assign a01 = RW'(i_in.m01);
    assign a02 = RW'(i_in.m02);
    assign a10 = RW'(i_in.m10);
    assign a11 = RW'(i_in.m11);
    assign a12 = RW'(i_in.m12);
    assign a20 = RW'(i_in.m20);
    assign a21 = RW'(i_in.m21);
    assign a22 = RW'(i_in.m22);
    assign trace = a00 + a11 + a22;
    assign one = {{(RW-1){1'b0}}, 1'b1} << F;

    always_comb begin
        if (trace > 0) begin
            n_ctl.branch = rmq_pkg::BR_TRACE;
            rad_s = one + trace;
            dv[0] = (W+2)'(a21 - a12);
            dv[1] = (W+2)'(a02 - a20);
            dv[2] = (W+2)'(a10 - a01);
        end else if (a00 > a11 && a00 > a22) begin
            n_ctl.branch = rmq_pkg::BR_X;
            rad_s = one + a00 - a11 - a22;
            dv[0] = (W+2)'(a01 + a10);
            dv[1] = (W+2)'(a02 + a20);
            dv[2] = (W+2)'(a21 - a12);
        end else if (a11 > a22) begin
            n_ctl.branch = rmq_pkg::BR_Y;
            rad_s = one + a11 - a00 - a22;
            dv[0] = (W+2)'(a01 + a10);
            dv[1] = (W+2)'(a12 + a21);
            dv[2] = (W+2)'(a02 - a20);
        end else begin
            n_ctl.branch = rmq_pkg::BR_Z;
            rad_s = one + a22 - a00 - a11;
            dv[0] = (W+2)'(a02 + a20);
            dv[1] = (W+2)'(a12 + a21);
            dv[2] = (W+2)'(a10 - a01);
        end
        n_ctl.err = (rad_s <= 0);
        n_rad = n_ctl.err ? '0 : {rad_s[RW-2:0], {F{1'b0}}};
        for (int l = 0; l < 3; l++) begin
            n_neg[l] = dv[l][W+1];
            n_mag[l] = n_neg[l] ? W'(0) + (W+1)'(-dv[l]) : (W+1)'(dv[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= n_ctl;
            r_rad <= n_rad;
            r_neg <= n_neg;
            r_mag <= n_mag;
        end
    end

    assign o_vld = r_vld;
    assign o_ctl = r_ctl;
    assign o_rad = r_rad;
    assign o_neg = r_neg;
    assign o_mag = r_mag;

endmodule

`default_nettype wire

>>> hw/rtl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module rmq_sqrt #(
    parameter int RADW = 33,
    parameter int SBW  = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_vld,
    input  wire logic [RADW-1:0]         i_rad,
    input  wire logic [SBW-1:0]          i_side,
    output logic                         o_vld,
    output logic [(RADW+1)/2-1:0]        o_root,
    output logic [SBW-1:0]               o_side
);

    localparam int RTW = (RADW + 1) / 2;
    localparam int PW  = 2 * RTW;

    logic [PW-1:0]  r_rad  [1:RTW-1];
    logic [RTW:0]   r_rem  [1:RTW-1];
    logic [RTW-1:0] r_root [1:RTW];
    logic [SBW-1:0] r_side [1:RTW];
    logic           r_vld  [1:RTW];

    for (genvar k = 0; k < RTW; k++) begin : g_stage
        logic [PW-1:0]  a_rad;
        logic [RTW:0]   a_rem;
        logic [RTW-1:0] a_root;
        logic [SBW-1:0] a_side;
        logic           a_vld;
        logic [RTW+2:0] c_rem, c_trial, c_new;
        logic           c_ge;

        if (k == 0) begin : g_first
            assign a_rad  = PW'(i_rad);
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_side = i_side;
            assign a_vld  = i_vld;
        end else begin : g_next
            assign a_rad  = r_rad[k];
            assign a_rem  = r_rem[k];
            assign a_root = r_root[k];
            assign a_side = r_side[k];
            assign a_vld  = r_vld[k];
        end

        assign c_rem   = {a_rem, a_rad[PW-1 -: 2]};
        assign c_trial = {1'b0, a_root, 2'b01};
        assign c_ge    = (c_rem >= c_trial);
        assign c_new   = c_ge ? (c_rem - c_trial) : c_rem;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k+1] <= {a_root[RTW-2:0], c_ge};
                r_side[k+1] <= a_side;
            end
        end

        if (k < RTW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[k+1] <= a_rad << 2;
                    r_rem[k+1] <= c_new[RTW:0];
                end
            end
        end
    end

    assign o_vld  = r_vld[RTW];
    assign o_root = r_root[RTW];
    assign o_side = r_side[RTW];

endmodule

`default_nettype wire

>>> hw/rtl/rmq_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one bit per stage.
`default_nettype none

module rmq_div #(
    parameter int W   = rmq_pkg::ELEM_WIDTH,
    parameter int F   = rmq_pkg::FRAC_BITS,
    parameter int RTW = 17,
    parameter int NW  = rmq_pkg::max_int(W + 1 + F, RTW) + 1,
    parameter int SBW = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  wire logic [2:0][W:0]      i_mag,
    input  wire logic [RTW-1:0]       i_root,
    input  wire logic [SBW-1:0]       i_side,
    output logic                      o_vld,
    output logic [2:0][NW-1:0]        o_quo,
    output logic [SBW-1:0]            o_side
);

    logic [2:0][NW-1:0]  r_nq   [1:NW];
    logic [2:0][RTW:0]   r_rem  [1:NW-1];
    logic [RTW:0]        r_den  [1:NW-1];
    logic [SBW-1:0]      r_side [1:NW];
    logic                r_vld  [1:NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [2:0][NW-1:0] a_nq;
        logic [2:0][RTW:0]  a_rem;
        logic [RTW:0]       a_den;
        logic [SBW-1:0]     a_side;
        logic               a_vld;
        logic [2:0][NW-1:0] c_nq;
        logic [2:0][RTW:0]  c_rem;

        if (k == 0) begin : g_first
            for (genvar l = 0; l < 3; l++) begin : g_num
                assign a_nq[l] = NW'({i_mag[l], {F{1'b0}}}) + NW'(i_root);
            end
            assign a_rem  = '0;
            assign a_den  = {i_root, 1'b0};
            assign a_side = i_side;
            assign a_vld  = i_vld;
        end else begin : g_next
            assign a_nq   = r_nq[k];
            assign a_rem  = r_rem[k];
            assign a_den  = r_den[k];
            assign a_side = r_side[k];
            assign a_vld  = r_vld[k];
        end

        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [RTW+1:0] c_try, c_new;
            logic           c_ge;
            assign c_try    = {a_rem[l], a_nq[l][NW-1]};
            assign c_ge     = (c_try >= {1'b0, a_den});
            assign c_new    = c_ge ? (c_try - {1'b0, a_den}) : c_try;
            assign c_rem[l] = c_new[RTW:0];
            assign c_nq[l]  = {a_nq[l][NW-2:0], c_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[k+1]   <= c_nq;
                r_side[k+1] <= a_side;
            end
        end

        if (k < NW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= c_rem;
                    r_den[k+1] <= a_den;
                end
            end
        end
    end

    assign o_vld  = r_vld[NW];
    assign o_quo  = r_nq[NW];
    assign o_side = r_side[NW];

endmodule

`default_nettype wire

>>> hw/rtl/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix to quaternion converter, Shepperd branch selection.
// The pipeline is one front stage, RTW square-root stages, NW divider stages
// and the output register. RTW is half the radicand width rounded up, NW is one
// more than the wider of the scaled numerator and the root.
// Throughput is one matrix per cycle; the whole pipeline holds when a result is stalled.
// Reset is synchronous and active low; it clears only the valid bits.
`default_nettype none

module rotation_matrix_to_quaternion #(
    parameter int ELEM_WIDTH = rmq_pkg::ELEM_WIDTH,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rmq_in_if.sink      i_in,
    rmq_out_if.source   o_out
);

    // Derived widths. The radicand carries FRAC_BITS more fraction bits so that
    // its root keeps FRAC_BITS fraction bits.
    localparam int W   = ELEM_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int RW  = rmq_pkg::max_int(W, F + 1) + 3;
    localparam int NRW = RW - 1 + F;
    localparam int RTW = (NRW + 1) / 2;
    localparam int NW  = rmq_pkg::max_int(W + 1 + F, RTW) + 1;
    localparam int SQW = 6 + 3 * (W + 1);
    localparam int DVW = 6 + W;

    // One enable moves every stage. The pipeline advances whenever the output
    // register is empty or its request is being taken.
    logic                r_out_vld;
    logic                en;

    logic                f_vld;
    rmq_pkg::t_ctl       f_ctl;
    logic [NRW-1:0]      f_rad;
    logic [2:0]          f_neg;
    logic [2:0][W:0]     f_mag;

    logic                s_vld;
    logic [RTW-1:0]      s_root;
    logic [SQW-1:0]      s_side;
    rmq_pkg::t_ctl       s_ctl;
    logic [2:0]          s_neg;
    logic [2:0][W:0]     s_mag;
    logic [RTW:0]        s_half;
    logic [W-1:0]        s_diag;

    logic                d_vld;
    logic [2:0][NW-1:0]  d_quo;
    logic [DVW-1:0]      d_side;
    rmq_pkg::t_ctl       d_ctl;
    logic [2:0]          d_neg;
    logic [W-1:0]        d_diag;
    logic [2:0][W-1:0]   d_lane;

    logic [NW-1:0]       max_pos;
    logic [NW-1:0]       max_neg;

    logic signed [W-1:0] n_qx, n_qy, n_qz, n_qw;
    logic signed [W-1:0] r_qx, r_qy, r_qz, r_qw;
    rmq_pkg::t_ctl       r_ctl;

    assign en = !r_out_vld || o_out.ready;

    rmq_front #(.W(W), .F(F), .RW(RW), .NRW(NRW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_in    (i_in),
        .o_vld   (f_vld),
        .o_ctl   (f_ctl),
        .o_rad   (f_rad),
        .o_neg   (f_neg),
        .o_mag   (f_mag)
    );

    rmq_sqrt #(.RADW(NRW), .SBW(SQW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_rad   (f_rad),
        .i_side  ({f_ctl, f_neg, f_mag}),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    assign {s_ctl, s_neg, s_mag} = s_side;

    // The largest component is s/4, which is the root rounded half up and
    // halved, then clipped to the most positive value.
    assign max_pos = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
    assign max_neg = max_pos + NW'(1);
    assign s_half  = ((RTW+1)'(s_root) + (RTW+1)'(1)) >> 1;
    assign s_diag  = (NW'(s_half) > max_pos) ? max_pos[W-1:0] : s_half[W-1:0];

    rmq_div #(.W(W), .F(F), .RTW(RTW), .NW(NW), .SBW(DVW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (s_vld),
        .i_mag   (s_mag),
        .i_root  (s_root),
        .i_side  ({s_ctl, s_neg, s_diag}),
        .o_vld   (d_vld),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    assign {d_ctl, d_neg, d_diag} = d_side;

    // Restore the sign of each quotient and clip it to the signed range. The
    // negative limit is one step further out than the positive one.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (!d_neg[l]) begin
                d_lane[l] = (d_quo[l] > max_pos) ? max_pos[W-1:0] : d_quo[l][W-1:0];
            end else if (d_quo[l] > max_neg) begin
                d_lane[l] = max_neg[W-1:0];
            end else begin
                d_lane[l] = W'(0) - d_quo[l][W-1:0];
            end
        end
    end

    // Place the diagonal component and the three quotients by branch. When the
    // radicand was not positive all four components are forced to zero.
    always_comb begin
        case (d_ctl.branch)
            rmq_pkg::BR_TRACE: begin
                n_qx = d_lane[0]; n_qy = d_lane[1]; n_qz = d_lane[2]; n_qw = d_diag;
            end
            rmq_pkg::BR_X: begin
                n_qx = d_diag; n_qy = d_lane[0]; n_qz = d_lane[1]; n_qw = d_lane[2];
            end
            rmq_pkg::BR_Y: begin
                n_qx = d_lane[0]; n_qy = d_diag; n_qz = d_lane[1]; n_qw = d_lane[2];
            end
            default: begin
                n_qx = d_lane[0]; n_qy = d_lane[1]; n_qz = d_diag; n_qw = d_lane[2];
            end
        endcase
        if (d_ctl.err) begin
            n_qx = '0;
            n_qy = '0;
            n_qz = '0;
            n_qw = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_qx  <= n_qx;
            r_qy  <= n_qy;
            r_qz  <= n_qz;
            r_qw  <= n_qw;
            r_ctl <= d_ctl;
        end
    end

    assign o_out.valid  = r_out_vld;
    assign o_out.qx     = r_qx;
    assign o_out.qy     = r_qy;
    assign o_out.qz     = r_qz;
    assign o_out.qw     = r_qw;
    assign o_out.branch = r_ctl.branch;
    assign o_out.error  = r_ctl.err;

    // A stalled result must hold back new requests.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while output is stalled");

    // An error result carries zero components.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error) |->
        (o_out.qx == '0 && o_out.qy == '0 && o_out.qz == '0 && o_out.qw == '0))
        else $error("error result with nonzero components");

    // The trace branch never has an error and its scalar part is non-negative.
    a_trace_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.branch == rmq_pkg::BR_TRACE) |->
        (!o_out.error && !o_out.qw[W-1]))
        else $error("trace branch gave error or negative scalar");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
